[sv/chol_pkg.sv]
// ----------------------------------------------------------------------------
// chol_pkg
// Shared types and constants for the Cholesky factor block.
// ----------------------------------------------------------------------------
package chol_pkg;

   // Data word and configuration port sizes.
   localparam int WORD_BITS     = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int STEP_BITS     = 5;

   // Register index taken from the byte address.
   localparam logic REG_MATRIX_SIZE = 1'b0;

   // Reset order of the matrix.
   localparam logic [3:0] SIZE_RESET = 4'd2;

   // Iterations of the shared root and divide unit.
   localparam logic [STEP_BITS-1:0] SQRT_LAST_STEP = 5'd31;
   localparam logic [STEP_BITS-1:0] DIV_LAST_STEP  = 5'd30;

   // Saturation limits.
   localparam logic [WORD_BITS-1:0] WORD_MAX = 32'h7FFF_FFFF;
   localparam logic [WORD_BITS-1:0] WORD_MIN = 32'h8000_0000;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic mem_we;
      logic wsel_load;
      logic acc_load;
      logic prod_load;
      logic acc_sub;
      logic op_start;
      logic op_diag;
      logic iter_step;
      logic form;
      logic out_load;
      logic out_last;
   } chol_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic special;
   } chol_status_type;

endpackage

[sv/chol_datapath.sv]
// ----------------------------------------------------------------------------
// chol_datapath
// Matrix store, multiply-accumulate, bit-serial root and divide unit and
// the result registers.
// ----------------------------------------------------------------------------
module chol_datapath #(
   parameter int MAX_ORDER = 8,
   parameter int FRAC_BITS = 16,
   parameter int AW        = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  chol_pkg::chol_cmd_type            cmd,
   output chol_pkg::chol_status_type         status,
   input  logic [AW-1:0]                     waddr,
   input  logic [AW-1:0]                     raddr_a,
   input  logic [AW-1:0]                     raddr_b,
   input  logic signed [31:0]                req_element,
   output logic signed [31:0]                rsp_factor_value,
   output logic                              rsp_last_of_run,
   output logic                              rsp_not_positive_definite
);
   import chol_pkg::*;

   localparam int STORE_DEPTH = MAX_ORDER * (MAX_ORDER + 1) / 2;
   localparam int SAT_SHIFT   = 31 - FRAC_BITS;
   localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

   logic [31:0]        mem [STORE_DEPTH];
   logic [31:0]        rd_a_ff, rd_b_ff;
   logic signed [63:0] acc_ff, prod_ff;
   logic [63:0]        x_ff;
   logic [35:0]        rem_ff;
   logic [31:0]        root_ff, d_ff, result_ff;
   logic               diag_ff, neg_ff, fault_ff;
   logic [31:0]        out_value_ff;
   logic               out_last_ff;
   logic               out_fault_ff;

   logic [31:0]        wdata;
   logic signed [31:0] a_s, b_s;
   logic signed [63:0] rprod;
   logic               r_pos, d_pos, sat_hit;
   logic [63:0]        mag, dsh, nshift;
   logic [31:0]        special_val;
   logic [35:0]        t_sq, trial_sq, t_dv, dd;
   logic               ge_sq, ge_dv;
   logic [31:0]        form_val;

   // Store write and registered reads.
   assign wdata = cmd.wsel_load ? req_element : result_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[waddr] <= wdata;
      end
      rd_a_ff <= mem[raddr_a];
      rd_b_ff <= mem[raddr_b];
   end

   // Rounded product and the tests made at the start of a root or divide.
   always_comb begin
      a_s         = rd_a_ff;
      b_s         = rd_b_ff;
      rprod       = (prod_ff + HALF) >>> FRAC_BITS;
      r_pos       = !acc_ff[63] && (acc_ff != 64'sd0);
      d_pos       = !rd_b_ff[31] && (rd_b_ff != 32'd0);
      mag         = acc_ff[63] ? 64'(-acc_ff) : 64'(acc_ff);
      dsh         = {32'd0, rd_b_ff} << SAT_SHIFT;
      sat_hit     = mag >= dsh;
      nshift      = mag << FRAC_BITS;
      if (cmd.op_diag) begin
         status.special = !r_pos;
         special_val    = 32'd0;
      end else begin
         status.special = !d_pos || sat_hit;
         special_val    = !d_pos ? 32'd0 : (acc_ff[63] ? WORD_MIN : WORD_MAX);
      end
   end

   // One step of the root and of the restoring divide.
   always_comb begin
      t_sq     = {rem_ff[33:0], x_ff[63:62]};
      trial_sq = {2'b00, root_ff, 2'b01};
      ge_sq    = t_sq >= trial_sq;
      t_dv     = {rem_ff[34:0], x_ff[63]};
      dd       = {4'd0, d_ff};
      ge_dv    = t_dv >= dd;
      if (diag_ff) begin
         form_val = root_ff[31] ? WORD_MAX : root_ff;
      end else begin
         form_val = neg_ff ? 32'(-root_ff) : root_ff;
      end
   end

   // Arithmetic registers.
   always_ff @(posedge clock) begin
      if (cmd.acc_load) begin
         acc_ff <= {{32{rd_a_ff[31]}}, rd_a_ff};
      end else if (cmd.acc_sub) begin
         acc_ff <= acc_ff - rprod;
      end
      if (cmd.prod_load) begin
         prod_ff <= 64'(a_s) * 64'(b_s);
      end
      if (cmd.op_start) begin
         diag_ff <= cmd.op_diag;
         neg_ff  <= acc_ff[63];
         d_ff    <= rd_b_ff;
         root_ff <= 32'd0;
         if (status.special) begin
            result_ff <= special_val;
         end
         if (cmd.op_diag) begin
            x_ff   <= 64'(acc_ff) << FRAC_BITS;
            rem_ff <= 36'd0;
         end else begin
            x_ff   <= {nshift[30:0], 33'd0};
            rem_ff <= {3'd0, nshift[63:31]};
         end
      end else if (cmd.iter_step) begin
         if (diag_ff) begin
            rem_ff  <= ge_sq ? (t_sq - trial_sq) : t_sq;
            root_ff <= {root_ff[30:0], ge_sq};
            x_ff    <= x_ff << 2;
         end else begin
            rem_ff  <= ge_dv ? (t_dv - dd) : t_dv;
            root_ff <= {root_ff[30:0], ge_dv};
            x_ff    <= x_ff << 1;
         end
      end else if (cmd.form) begin
         result_ff <= form_val;
      end
      // The fault flag is captured with its beat so that a later entry
      // cannot change a beat that is still waiting.
      if (cmd.out_load) begin
         out_value_ff <= result_ff;
         out_last_ff  <= cmd.out_last;
         out_fault_ff <= fault_ff;
      end
   end

   // Sticky fault flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         fault_ff <= 1'b0;
      end else if (cmd.op_start && cmd.op_diag && !r_pos) begin
         fault_ff <= 1'b1;
      end
   end

   assign rsp_factor_value          = out_value_ff;
   assign rsp_last_of_run           = out_last_ff;
   assign rsp_not_positive_definite = out_fault_ff;

endmodule

[sv/chol_ctrl.sv]
// ----------------------------------------------------------------------------
// chol_ctrl
// Controller: size register, load counter, row and column sequencing and
// the result handshake.
// ----------------------------------------------------------------------------
module chol_ctrl #(
   parameter int MAX_ORDER = 8,
   parameter int AW        = 6
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [chol_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready,
   output chol_pkg::chol_cmd_type                cmd,
   input  chol_pkg::chol_status_type             status,
   output logic [AW-1:0]                         waddr,
   output logic [AW-1:0]                         raddr_a,
   output logic [AW-1:0]                         raddr_b
);
   import chol_pkg::*;

   localparam int STORE_DEPTH = MAX_ORDER * (MAX_ORDER + 1) / 2;
   localparam int CW          = $clog2(MAX_ORDER + 1);
   localparam int LCW         = $clog2(STORE_DEPTH + 1);

   typedef enum logic [10:0] {
      S_LOAD  = 11'b000_0000_0001,
      S_INIT  = 11'b000_0000_0010,
      S_ACC   = 11'b000_0000_0100,
      S_MREAD = 11'b000_0000_1000,
      S_MMUL  = 11'b000_0001_0000,
      S_MACC  = 11'b000_0010_0000,
      S_FIN   = 11'b000_0100_0000,
      S_OPST  = 11'b000_1000_0000,
      S_ITER  = 11'b001_0000_0000,
      S_FORM  = 11'b010_0000_0000,
      S_EMIT  = 11'b100_0000_0000
   } chol_state_type;

   chol_state_type          state_ff, state_in;
   logic [3:0]              size_ff, size_in;
   logic [LCW-1:0]          load_cnt_ff, load_cnt_in;
   logic [CW-1:0]           i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [AW-1:0]           base_i_ff, base_i_in, base_j_ff, base_j_in;
   logic [STEP_BITS-1:0]    step_ff, step_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0]           n_use;
   logic [LCW-1:0]          total;
   logic                    cfg_we, req_take, out_free, is_diag, is_last;

   // Configuration port.
   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_MATRIX_SIZE);
   assign prdata = (paddr[2] == REG_MATRIX_SIZE) ? {28'd0, size_ff} : 32'd0;

   // Order in use and element count of the triangle.
   always_comb begin
      if (size_ff == 4'd0) begin
         n_use = CW'(1);
      end else if (32'(size_ff) > MAX_ORDER) begin
         n_use = CW'(MAX_ORDER);
      end else begin
         n_use = CW'(size_ff);
      end
      total = LCW'((32'(n_use) * (32'(n_use) + 32'd1)) >> 1);
   end

   assign req_stall = (state_ff != S_LOAD);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_diag   = (i_ff == j_ff);
   assign is_last   = is_diag && (i_ff == n_use - CW'(1));

   // Store addresses.
   assign raddr_a = base_i_ff + AW'((state_ff == S_INIT) ? j_ff : k_ff);
   assign raddr_b = base_j_ff + AW'(k_ff);
   assign waddr   = (state_ff == S_LOAD) ? load_cnt_ff[AW-1:0] : base_i_ff + AW'(j_ff);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      load_cnt_in  = load_cnt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      base_i_in    = base_i_ff;
      base_j_in    = base_j_ff;
      step_in      = step_ff;
      cmd          = '0;
      cmd.op_diag  = is_diag;
      cmd.out_last = is_last;

      case (state_ff)
         S_LOAD: begin
            if (req_take) begin
               cmd.mem_we    = 1'b1;
               cmd.wsel_load = 1'b1;
               if (load_cnt_ff + LCW'(1) == total) begin
                  load_cnt_in = '0;
                  state_in    = S_INIT;
               end else begin
                  load_cnt_in = load_cnt_ff + LCW'(1);
               end
            end
         end
         S_INIT: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc_load = 1'b1;
            k_in         = '0;
            state_in     = (j_ff == '0) ? S_FIN : S_MREAD;
         end
         S_MREAD: begin
            state_in = S_MMUL;
         end
         S_MMUL: begin
            cmd.prod_load = 1'b1;
            state_in      = S_MACC;
         end
         S_MACC: begin
            cmd.acc_sub = 1'b1;
            k_in        = k_ff + CW'(1);
            state_in    = (k_ff + CW'(1) == j_ff) ? S_FIN : S_MREAD;
         end
         S_FIN: begin
            state_in = S_OPST;
         end
         S_OPST: begin
            cmd.op_start = 1'b1;
            step_in      = is_diag ? SQRT_LAST_STEP : DIV_LAST_STEP;
            state_in     = status.special ? S_EMIT : S_ITER;
         end
         S_ITER: begin
            cmd.iter_step = 1'b1;
            step_in       = step_ff - STEP_BITS'(1);
            if (step_ff == '0) begin
               state_in = S_FORM;
            end
         end
         S_FORM: begin
            cmd.form = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.mem_we   = 1'b1;
               cmd.out_load = 1'b1;
               if (is_last) begin
                  i_in      = '0;
                  j_in      = '0;
                  base_i_in = '0;
                  base_j_in = '0;
                  state_in  = S_LOAD;
               end else if (is_diag) begin
                  i_in      = i_ff + CW'(1);
                  j_in      = '0;
                  base_i_in = base_i_ff + AW'(i_ff) + AW'(1);
                  base_j_in = '0;
                  state_in  = S_INIT;
               end else begin
                  j_in      = j_ff + CW'(1);
                  base_j_in = base_j_ff + AW'(j_ff) + AW'(1);
                  state_in  = S_INIT;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      // A size write drops a partly loaded matrix.
      if (cfg_we) begin
         size_in     = pwdata[3:0];
         load_cnt_in = '0;
      end
   end

   // Result valid flag.
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         size_ff      <= SIZE_RESET;
         load_cnt_ff  <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         base_i_ff    <= '0;
         base_j_ff    <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         load_cnt_ff  <= load_cnt_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         base_i_ff    <= base_i_in;
         base_j_ff    <= base_j_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[sv/cholesky_factor.sv]
// ----------------------------------------------------------------------------
// cholesky_factor
// Streaming lower Cholesky factorization of a symmetric matrix in signed
// fixed point.
// ----------------------------------------------------------------------------
// The block loads the lower triangle of an n x n matrix, row-major, one
// element per beat at one beat per cycle, then stalls its input while it
// factors and emits L in the same order, the final entry marked. Each entry
// (i,j) takes a read, a multiply and an accumulate step for each of its j
// product terms in the shared multiply-accumulate, then the bit-serial square
// root or the restoring divide in the shared root and divide unit. The last
// result may wait in the output register while the next matrix loads.
// ----------------------------------------------------------------------------
module cholesky_factor #(
   parameter int MAX_ORDER = 8,
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [31:0]                    req_element,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [31:0]                    rsp_factor_value,
   output logic                                  rsp_last_of_run,
   output logic                                  rsp_not_positive_definite,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [chol_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [31:0]                           pwdata,
   output logic [31:0]                           prdata,
   output logic                                  pready
);
   import chol_pkg::*;

   localparam int STORE_DEPTH = MAX_ORDER * (MAX_ORDER + 1) / 2;
   localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   chol_cmd_type    cmd;
   chol_status_type status;
   logic [AW-1:0]   waddr, raddr_a, raddr_b;

   // Sequencing and handshakes.
   chol_ctrl #(
      .MAX_ORDER (MAX_ORDER),
      .AW        (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .cmd       (cmd),
      .status    (status),
      .waddr     (waddr),
      .raddr_a   (raddr_a),
      .raddr_b   (raddr_b)
   );

   // Store and arithmetic.
   chol_datapath #(
      .MAX_ORDER (MAX_ORDER),
      .FRAC_BITS (FRAC_BITS),
      .AW        (AW)
   ) u_datapath (
      .clock                     (clock),
      .reset                     (reset),
      .cmd                       (cmd),
      .status                    (status),
      .waddr                     (waddr),
      .raddr_a                   (raddr_a),
      .raddr_b                   (raddr_b),
      .req_element               (req_element),
      .rsp_factor_value          (rsp_factor_value),
      .rsp_last_of_run           (rsp_last_of_run),
      .rsp_not_positive_definite (rsp_not_positive_definite)
   );

endmodule

[verif/tb_cholesky_factor.sv]
// ----------------------------------------------------------------------------
// tb_cholesky_factor
// Self-checking testbench for the streaming Cholesky factor block.
// ----------------------------------------------------------------------------
// A driver sends matrix elements from a queue. A built-in predictor keeps
// its own copy of the element store, the load count, the fault flag and the
// matrix order. It factors each complete matrix in fixed point and queues
// the expected factor beats. A monitor checks every result beat against the
// oldest expected one. The order is changed over the register port only
// while the block is idle. The stimulus is directed cases first, then
// random, mostly well-formed, matrices of mostly small order.
// ----------------------------------------------------------------------------
module tb_cholesky_factor;
   import chol_pkg::*;

   localparam int ORDER_MAX   = 8;
   localparam int Q_BITS      = 16;
   localparam int STORE_WORDS = ORDER_MAX * (ORDER_MAX + 1) / 2;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_CYCLES = 400;
   localparam int REG_UNUSED  = 1;

   typedef struct packed {
      logic [31:0] value;
      logic        last;
      logic        fault;
   } factor_beat_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [31:0] req_element;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [31:0] rsp_factor_value;
   logic rsp_last_of_run;
   logic rsp_not_positive_definite;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   // Predictor state.
   logic [31:0] elem_store [STORE_WORDS];
   int unsigned load_cnt;
   logic        fault_flag;
   logic [3:0]  order_reg;

   logic [31:0]     pending_elems [$];
   factor_beat_type expected_beats [$];
   int  mismatch_count;
   int  send_gap;
   int  recv_gap;
   int  hold_left;
   logic hold_start;
   logic no_idle;
   int  cycle_count;
   int  items_queued;

   cholesky_factor i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_element(req_element),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_factor_value(rsp_factor_value), .rsp_last_of_run(rsp_last_of_run),
      .rsp_not_positive_definite(rsp_not_positive_definite),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Mostly short gaps, some long ones, none at all in quiet phases.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (no_idle || roll < 55) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic int unsigned order_used();
      if (order_reg == 4'd0) return 1;
      if (order_reg > ORDER_MAX) return ORDER_MAX;
      return order_reg;
   endfunction

   // Product of two Q values, rounded to nearest with ties upward.
   function automatic longint q_mul_round(longint a, longint b);
      longint p;
      p = a * b + (longint'(1) << (Q_BITS - 1));
      return p >>> Q_BITS;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Residual over pivot in Q format, truncated, saturated, zero pivot gives 0.
   function automatic longint q_div(longint r, longint d);
      logic [63:0] mag;
      logic [63:0] q;
      if (d <= 0) return 0;
      mag = (r < 0) ? 64'(-r) : 64'(r);
      if (mag / 64'(d) >= (64'd1 << (31 - Q_BITS)))
         return (r < 0) ? -longint'(64'h8000_0000) : longint'(32'h7FFF_FFFF);
      q = (mag << Q_BITS) / 64'(d);
      return (r < 0) ? -longint'(q) : longint'(q);
   endfunction

   // Factors the loaded matrix row by row and queues the expected beats.
   task automatic factor_loaded_matrix(int unsigned n);
      longint lf [ORDER_MAX][ORDER_MAX];
      longint r;
      longint v;
      int unsigned idx;
      int unsigned total;
      factor_beat_type beat;
      idx = 0;
      total = n * (n + 1) / 2;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j <= i; j++) begin
            r = longint'(signed'(elem_store[idx]));
            for (int k = 0; k < j; k++) r -= q_mul_round(lf[i][k], lf[j][k]);
            if (j == i) begin
               if (r <= 0) begin
                  v = 0;
                  fault_flag = 1'b1;
               end else begin
                  v = longint'(int_sqrt(64'(r) << Q_BITS));
                  if (v > longint'(32'h7FFF_FFFF)) v = longint'(32'h7FFF_FFFF);
               end
            end else begin
               v = q_div(r, lf[j][j]);
            end
            lf[i][j] = v;
            beat.value = v[31:0];
            beat.last = (idx + 1 == total);
            beat.fault = fault_flag;
            expected_beats.push_back(beat);
            idx++;
         end
      end
   endtask

   task automatic load_element(logic [31:0] value);
      int unsigned n;
      n = order_used();
      if (load_cnt < STORE_WORDS) elem_store[load_cnt] = value;
      load_cnt = (load_cnt + 1) & 6'h3F;
      if (load_cnt >= n * (n + 1) / 2) begin
         load_cnt = 0;
         factor_loaded_matrix(n);
      end
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // Element driver.
   always @(posedge clock) begin
      logic nv;
      logic [31:0] ne;
      if (reset) begin
         req_valid <= 1'b0;
         req_element <= '0;
         send_gap = 0;
      end else begin
         nv = req_valid;
         ne = req_element;
         if (req_valid && !req_stall) begin
            load_element(req_element);
            nv = 1'b0;
         end
         if (!nv) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_elems.size() > 0) begin
               ne = pending_elems.pop_front();
               nv = 1'b1;
               send_gap = pick_gap();
            end
         end
         req_valid <= nv;
         req_element <= ne;
      end
   end

   // Long receiver hold-off, counted here.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_start) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Result monitor and stall generator.
   always @(posedge clock) begin
      factor_beat_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               report_mismatch("unexpected beat", rsp_factor_value, 32'h0);
            end else begin
               want = expected_beats.pop_front();
               if (rsp_factor_value !== want.value)
                  report_mismatch("factor_value", rsp_factor_value, want.value);
               if (rsp_last_of_run !== want.last)
                  report_mismatch("last_of_run", 32'(rsp_last_of_run), 32'(want.last));
               if (rsp_not_positive_definite !== want.fault)
                  report_mismatch("not_positive_definite",
                                  32'(rsp_not_positive_definite), 32'(want.fault));
            end
         end
         if (recv_gap > 0) recv_gap--;
         else recv_gap = pick_gap();
         rsp_stall <= (hold_left > 1) || (recv_gap > 0);
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("cholesky_factor test failed");
         $finish;
      end
   end

   task automatic csr_write(int index, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_BITS'(4 * index);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (index == int'(REG_MATRIX_SIZE)) begin
         order_reg = value[3:0];
         load_cnt = 0;
      end
   endtask

   task automatic wait_idle();
      while (pending_elems.size() > 0 || req_valid || expected_beats.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic queue_elements(logic [31:0] elems []);
      foreach (elems[i]) pending_elems.push_back(elems[i]);
      items_queued += elems.size();
   endtask

   // Symmetric positive definite matrix built as L*L^T from a random L.
   task automatic queue_good_matrix(int unsigned n);
      longint lm [ORDER_MAX][ORDER_MAX];
      longint a;
      for (int i = 0; i < n; i++)
         for (int j = 0; j <= i; j++)
            lm[i][j] = (j == i) ? longint'($urandom_range(32'h3_0000, 32'h0_4000))
                                : longint'($urandom_range(32'h4_0000)) - 32'h2_0000;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j <= i; j++) begin
            a = 0;
            for (int k = 0; k <= j; k++) a += (lm[i][k] * lm[j][k]) >>> Q_BITS;
            a += longint'($urandom_range(15)) - 7;
            pending_elems.push_back(a[31:0]);
            items_queued++;
         end
      end
   endtask

   task automatic queue_noise_matrix(int unsigned n);
      logic [31:0] e;
      for (int i = 0; i < n * (n + 1) / 2; i++) begin
         case ($urandom_range(3))
            0: e = 32'h8000_0000;
            1: e = 32'h7FFF_FFFF;
            default: e = $urandom();
         endcase
         pending_elems.push_back(e);
         items_queued++;
      end
   endtask

   function automatic int unsigned pick_order();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5) return 0;
      if (roll < 8) return $urandom_range(15, 9);
      if (roll < 14) return 8;
      return $urandom_range(5, 1);
   endfunction

   initial begin
      int unsigned n;
      int phase;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      hold_start = 1'b0;
      no_idle = 1'b0;
      cycle_count = 0;
      mismatch_count = 0;
      items_queued = 0;
      load_cnt = 0;
      fault_flag = 1'b0;
      order_reg = SIZE_RESET;
      foreach (elem_store[i]) elem_store[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset order, order one, the largest order, clamped orders.
      queue_elements('{32'h0004_0000, 32'h0002_0000, 32'h0005_0000});
      wait_idle();
      csr_write(REG_UNUSED, 32'd5);
      queue_elements('{32'h0001_0000, 32'h0000_8000, 32'h0001_0000});
      wait_idle();
      csr_write(REG_MATRIX_SIZE, 32'd1);
      queue_elements('{32'h7FFF_FFFF, 32'h0000_0001});
      wait_idle();
      csr_write(REG_MATRIX_SIZE, 32'd8);
      queue_good_matrix(8);
      wait_idle();
      // A partly loaded matrix is dropped by the register write.
      csr_write(REG_MATRIX_SIZE, 32'd3);
      queue_elements('{32'h1234_5678, 32'h0000_1000});
      wait_idle();
      csr_write(REG_MATRIX_SIZE, 32'd0);
      queue_elements('{32'h0000_4000});
      wait_idle();
      // Saturating off-diagonal quotients.
      csr_write(REG_MATRIX_SIZE, 32'd2);
      queue_elements('{32'h0000_0001, 32'h7FFF_FFFF, 32'h0001_0000});
      queue_elements('{32'h0000_0001, 32'h8000_0000, 32'h0001_0000});
      wait_idle();
      // Not positive definite: zero pivot, then negative pivot, then a
      // clamped order above the maximum.
      csr_write(REG_MATRIX_SIZE, 32'd3);
      queue_elements('{32'h0000_0000, 32'h0001_0000, 32'h0001_0000,
                       32'h0001_0000, 32'h0002_0000, 32'h8000_0000});
      wait_idle();
      csr_write(REG_MATRIX_SIZE, 32'd15);
      queue_noise_matrix(8);
      wait_idle();

      // Random phases of matrices at one order each.
      phase = 0;
      while (items_queued < 500) begin
         n = pick_order();
         csr_write(REG_MATRIX_SIZE, 32'(n));
         if (n == 0) n = 1;
         if (n > ORDER_MAX) n = ORDER_MAX;
         no_idle = ($urandom_range(4) == 0);
         for (int m = $urandom_range(4, 1); m > 0; m--) begin
            if ($urandom_range(99) < 80) queue_good_matrix(n);
            else queue_noise_matrix(n);
         end
         if (phase == 3) begin
            @(posedge clock);
            hold_start <= 1'b1;
            @(posedge clock);
            hold_start <= 1'b0;
         end
         wait_idle();
         phase++;
      end
      no_idle = 1'b0;

      wait_idle();
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && expected_beats.size() == 0) begin
         $display("cholesky_factor test passed");
      end else begin
         $display("cholesky_factor test failed");
      end
      $finish;
   end

endmodule
